// File: hw/rtl/wtst_pkg.sv
// Shared types and constants for the windowed threshold trim core.
`timescale 1ns / 1ps

package wtst_pkg;

   localparam int unsigned SAMPLE_WIDTH = 16;
   localparam int unsigned LEN_WIDTH    = 16;
   localparam int unsigned REQ_DATA_W   = SAMPLE_WIDTH + LEN_WIDTH;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 16;

   localparam logic [7:0] LEAD_OFFSET = 8'd10;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WIN_LEN       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_HITS      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_CAP    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_TRIM_FRAC = 3'd4;

   typedef struct packed {
      logic [7:0]         win_len;
      logic signed [15:0] threshold;
      logic [7:0]         min_hits;
      logic [15:0]        sample_cap;
      logic [7:0]         max_trim_frac;
   } wtst_cfg_type;

   typedef struct packed {
      logic        emit;
      logic [15:0] trim_point;
      logic        from_window;
   } wtst_res_type;

endpackage

// File: hw/rtl/windowed_threshold_signal_trim_core.sv
// Top level: input register, trim engine, result register and config port.
`timescale 1ns / 1ps
// A word accepted into the input register has any result it produces loaded
//   into the result register when the engine steps on it; a held result delays that.
// Throughput: one word per cycle while results are taken, set by the window state update.
// A result waiting on rsp_tready does not block intake until the input register
//   is also full. Reset is synchronous: registers return to defaults, read state clears.

module windowed_threshold_signal_trim_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [wtst_pkg::REQ_DATA_W-1:0]      req_tdata,  // sample, read_length
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,  // trim_point
   output logic                                 rsp_tuser,  // from_window
   input  logic                                 csr_we,
   input  logic [wtst_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [wtst_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import wtst_pkg::*;

   wtst_cfg_type cfg;
   wtst_res_type res;

   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic [LEN_WIDTH-1:0]           in_len_ff;
   logic                           in_last_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_trim_ff;
   logic        rsp_from_win_ff;

   logic out_free;
   logic step;
   logic req_fire;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   wtst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wtst_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step),
      .sample      (in_sample_ff),
      .read_length (in_len_ff),
      .last        (in_last_ff),
      .cfg         (cfg),
      .res         (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = res.emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= $signed(req_tdata[SAMPLE_WIDTH-1:0]);
         in_len_ff    <= req_tdata[REQ_DATA_W-1:SAMPLE_WIDTH];
         in_last_ff   <= req_tlast;
      end
      // Hold the result word until the engine produces the next one
      if (step && res.emit) begin
         rsp_trim_ff     <= res.trim_point;
         rsp_from_win_ff <= res.from_window;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_trim_ff;
   assign rsp_tuser  = rsp_from_win_ff;

`ifndef SYNTH
   a_window_past_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata > 16'(LEAD_OFFSET))
      else $error("window trim not beyond lead offset");

   a_default_is_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'(LEAD_OFFSET))
      else $error("default trim differs from lead offset");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(step))
      else $error("result word without a processed sample");
`endif

endmodule

// File: hw/rtl/wtst_csr.sv
// Configuration register file for the trim core.
`timescale 1ns / 1ps

module wtst_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [wtst_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [wtst_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output wtst_pkg::wtst_cfg_type              cfg
);
   import wtst_pkg::*;

   wtst_cfg_type cfg_ff;
   wtst_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_WIN_LEN:       cfg_in.win_len       = csr_wdata[7:0];
            CSR_THRESHOLD:     cfg_in.threshold     = $signed(csr_wdata[15:0]);
            CSR_MIN_HITS:      cfg_in.min_hits      = csr_wdata[7:0];
            CSR_SAMPLE_CAP:    cfg_in.sample_cap    = csr_wdata[15:0];
            CSR_MAX_TRIM_FRAC: cfg_in.max_trim_frac = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_len       <= 8'd40;
         cfg_ff.threshold     <= 16'sd614;
         cfg_ff.min_hits      <= 8'd3;
         cfg_ff.sample_cap    <= 16'd8000;
         cfg_ff.max_trim_frac <= 8'd77;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/wtst_engine.sv
// Per-read window state and trim decision, one sample per step.
`timescale 1ns / 1ps

module wtst_engine (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step_en,
   input  logic signed [wtst_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic [wtst_pkg::LEN_WIDTH-1:0]           read_length,
   input  logic                                     last,
   input  wtst_pkg::wtst_cfg_type                   cfg,
   output wtst_pkg::wtst_res_type                   res
);
   import wtst_pkg::*;

   logic [15:0] sample_index_ff, sample_index_in;
   logic [7:0]  window_pos_ff,   window_pos_in;
   logic [15:0] windows_done_ff, windows_done_in;
   logic [7:0]  above_count_ff,  above_count_in;
   logic        peak_seen_ff,    peak_seen_in;
   logic        decided_ff,      decided_in;

   logic        above;
   logic [15:0] sample_limit;
   logic [23:0] done_span;
   logic [24:0] win_hi;
   logic [25:0] end_pt;
   logic [23:0] trim_lim;
   logic        active;
   logic        too_far;
   logic        now;

   assign above        = sample > cfg.threshold;
   assign sample_limit = (cfg.sample_cap < read_length) ? cfg.sample_cap : read_length;

   // Window k is examined while (k+1)*window length still fits in the capped count
   assign done_span = 24'(windows_done_ff) * 24'(cfg.win_len);
   assign win_hi    = 25'(done_span) + 25'(cfg.win_len);
   assign end_pt    = 26'(win_hi) + 26'(LEAD_OFFSET);
   assign trim_lim  = 24'(cfg.max_trim_frac) * 24'(read_length);

   assign active  = (sample_index_ff >= 16'(LEAD_OFFSET)) && (cfg.win_len != 8'd0)
                    && (win_hi <= 25'(sample_limit));
   assign too_far = (end_pt >= 26'(sample_limit)) || ({end_pt, 8'd0} >= 34'(trim_lim));

   always_comb begin
      sample_index_in  = sample_index_ff;
      window_pos_in    = window_pos_ff;
      windows_done_in  = windows_done_ff;
      above_count_in   = above_count_ff;
      peak_seen_in     = peak_seen_ff;
      decided_in       = decided_ff;
      now              = 1'b0;
      res.emit         = 1'b0;
      res.trim_point   = 16'(LEAD_OFFSET);
      res.from_window  = 1'b0;

      if (!decided_ff) begin
         if (active) begin
            if (above) begin
               above_count_in = above_count_ff + 8'd1;
            end
            window_pos_in = window_pos_ff + 8'd1;
            if ((window_pos_in >= cfg.win_len) || last) begin
               if ((above_count_in > cfg.min_hits) || peak_seen_ff) begin
                  peak_seen_in = 1'b1;
                  now          = !above;
               end
               if (!now) begin
                  windows_done_in = windows_done_ff + 16'd1;
                  window_pos_in   = 8'd0;
                  above_count_in  = 8'd0;
               end
            end
         end

         if (sample_index_ff != 16'hFFFF) begin
            sample_index_in = sample_index_ff + 16'd1;
         end

         if (now || last) begin
            res.emit = 1'b1;
            if (now && !too_far) begin
               res.trim_point  = end_pt[15:0];
               res.from_window = 1'b1;
            end
            decided_in = 1'b1;
         end
      end

      // Drop all read state at the end of the read
      if (last) begin
         sample_index_in = 16'd0;
         window_pos_in   = 8'd0;
         windows_done_in = 16'd0;
         above_count_in  = 8'd0;
         peak_seen_in    = 1'b0;
         decided_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= 16'd0;
         window_pos_ff   <= 8'd0;
         windows_done_ff <= 16'd0;
         above_count_ff  <= 8'd0;
         peak_seen_ff    <= 1'b0;
         decided_ff      <= 1'b0;
      end else if (step_en) begin
         sample_index_ff <= sample_index_in;
         window_pos_ff   <= window_pos_in;
         windows_done_ff <= windows_done_in;
         above_count_ff  <= above_count_in;
         peak_seen_ff    <= peak_seen_in;
         decided_ff      <= decided_in;
      end
   end

`ifndef SYNTH
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && last |=> (sample_index_ff == 16'd0) && !decided_ff
                          && (windows_done_ff == 16'd0) && !peak_seen_ff)
      else $error("read state not cleared after last word");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      decided_ff |-> !res.emit)
      else $error("second result for one read");

   a_window_implies_peak: assert property (@(posedge clock) disable iff (reset)
      step_en && res.from_window |=> peak_seen_ff || $past(last))
      else $error("window trim chosen without a peak");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the windowed threshold trim core: directed and random reads.
`timescale 1ns / 1ps

module tb_top;
   import wtst_pkg::*;

   localparam int unsigned IDLE_MAX      = 13;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_WORDS  = 200;
   localparam int unsigned HOLD_STRETCH  = 300;
   localparam int unsigned PRINT_LIMIT   = 40;

   typedef struct {
      logic [15:0] trim_point;
      logic        from_window;
   } trim_result_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [15:0]             rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // Shadow registers, at their reset values
   logic [7:0]              ws_cfg   = 8'd40;
   logic signed [15:0]      thr_cfg  = 16'sd614;
   logic [7:0]              min_cfg  = 8'd3;
   logic [15:0]             cap_cfg  = 16'd8000;
   logic [7:0]              frac_cfg = 8'd77;

   // Per-read scan state
   logic [15:0]             rd_index  = '0;
   logic [7:0]              win_pos   = '0;
   logic [15:0]             win_done  = '0;
   logic [7:0]              hit_count = '0;
   logic                    peak_flag = 1'b0;
   logic                    done_flag = 1'b0;

   trim_result_type         trim_expect_q[$];

   bit                      src_idle_en = 1'b1;
   bit                      snk_idle_en = 1'b1;
   int unsigned             hold_cycles = 0;

   int unsigned             mismatch_count = 0;
   int unsigned             trims_seen     = 0;
   int unsigned             words_scanned  = 0;
   int unsigned             words_skipped  = 0;
   int unsigned             reads_sent     = 0;
   int unsigned             config_phases  = 0;

   always #5 clock = ~clock;

   windowed_threshold_signal_trim_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   task automatic clear_read_state();
      rd_index  = '0;
      win_pos   = '0;
      win_done  = '0;
      hit_count = '0;
      peak_flag = 1'b0;
      done_flag = 1'b0;
   endtask

   // Advance the scan state by one word; queue the trim result it produces, if any.
   task automatic predict_trim(input logic signed [15:0] smp, input logic [15:0] len,
                               input logic is_last, output bit scanned);
      logic              above;
      int unsigned       n_samp;
      int unsigned       n_win;
      longint unsigned   win_end;
      bit                decide;
      trim_result_type   res;
      above           = (smp > thr_cfg);
      decide          = 1'b0;
      res.trim_point  = 16'(LEAD_OFFSET);
      res.from_window = 1'b0;
      scanned         = !done_flag;
      if (done_flag) begin
         // drop everything until the end of the read
         if (is_last) clear_read_state();
      end else begin
         n_samp = (cap_cfg < len) ? 32'(cap_cfg) : 32'(len);
         n_win  = (ws_cfg != 0) ? n_samp / 32'(ws_cfg) : 0;
         if (rd_index >= 16'(LEAD_OFFSET) && 32'(win_done) < n_win) begin
            if (above) hit_count = hit_count + 8'd1;
            win_pos = win_pos + 8'd1;
            if (win_pos >= ws_cfg || is_last) begin
               // nominal end, even for a window clipped by the end of the read
               win_end = 64'(win_done) * 64'(ws_cfg) + 64'(LEAD_OFFSET) + 64'(ws_cfg);
               if (hit_count > min_cfg || peak_flag) begin
                  peak_flag = 1'b1;
                  if (!above) begin
                     decide = 1'b1;
                     if (!(win_end >= 64'(n_samp) ||
                           win_end * 64'd256 >= 64'(frac_cfg) * 64'(len))) begin
                        res.trim_point  = win_end[15:0];
                        res.from_window = 1'b1;
                     end
                  end
               end
               if (!decide) begin
                  win_done  = win_done + 16'd1;
                  win_pos   = '0;
                  hit_count = '0;
               end
            end
         end
         if (rd_index != 16'hFFFF) rd_index = rd_index + 16'd1;
         if (decide || is_last) begin
            trim_expect_q.insert(trim_expect_q.size(), res);
            if (is_last) clear_read_state();
            else done_flag = 1'b1;
         end
      end
   endtask

   task automatic send_word(input logic signed [15:0] smp, input logic [15:0] len,
                            input logic is_last);
      int unsigned gap;
      bit          scanned;
      gap = src_idle_en ? $urandom_range(IDLE_MAX, 0) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, smp};
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      predict_trim(smp, len, is_last, scanned);
      if (scanned) words_scanned++;
      else words_skipped++;
      if (is_last) reads_sent++;
   endtask

   task automatic send_flat(input int unsigned n, input logic signed [15:0] smp,
                            input logic [15:0] len);
      repeat (n) send_word(smp, len, 1'b0);
   endtask

   // Drain all results and let any word still inside the core settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (trim_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIN_LEN:       ws_cfg   = val[7:0];
         CSR_THRESHOLD:     thr_cfg  = val;
         CSR_MIN_HITS:      min_cfg  = val[7:0];
         CSR_SAMPLE_CAP:    cap_cfg  = val;
         CSR_MAX_TRIM_FRAC: frac_cfg = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] ws, input logic signed [15:0] thr,
                             input logic [7:0] mn, input logic [15:0] cap,
                             input logic [7:0] frac);
      wait_idle();
      write_reg(CSR_WIN_LEN, 16'(ws));
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_MIN_HITS, 16'(mn));
      write_reg(CSR_SAMPLE_CAP, cap);
      write_reg(CSR_MAX_TRIM_FRAC, 16'(frac));
      config_phases++;
   endtask

   function automatic int clamp_q88(input int v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
   endfunction

   // One read with bursts above and below the threshold; one in ten is malformed.
   task automatic send_random_read();
      int unsigned n;
      int unsigned len;
      logic [15:0] len_w;
      bit          noise;
      bit          hi;
      int          t;
      int          v;
      noise = ($urandom_range(9, 0) == 0);
      t     = int'(thr_cfg);
      if (ws_cfg == 0) n = $urandom_range(20, 1);
      else n = 32'(LEAD_OFFSET) + 32'(ws_cfg) * $urandom_range((ws_cfg > 8) ? 2 : 6, 1)
               + $urandom_range(3, 0);
      if (noise) begin
         len = $urandom_range(65535, 0);
         n   = $urandom_range(n, 1);
      end else begin
         len = n;
      end
      hi = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(2, 0) == 0) hi = !hi;
         case ($urandom_range(15, 0))
            0: v = int'($urandom_range(65535, 0)) - 32768;
            1: v = t;
            default: v = hi ? clamp_q88(t + 1 + int'($urandom_range(300, 0)))
                            : clamp_q88(t - int'($urandom_range(300, 0)));
         endcase
         len_w = 16'(len);
         if (noise && $urandom_range(3, 0) == 0) len_w = 16'($urandom_range(65535, 0));
         send_word(16'(v), len_w, i == n - 1);
      end
   endtask

   task automatic test_defaults();
      send_word(16'sh7FFF, 16'd1, 1'b1);
      send_word(16'sh8000, 16'd12, 1'b0);
      send_flat(10, 16'sd700, 16'd12);
      send_word(16'sd0, 16'd12, 1'b1);
   endtask

   task automatic test_window_decision();
      logic [7:0] fracs [2];
      fracs = '{8'd255, 8'd0};
      foreach (fracs[i]) begin
         set_config(8'd1, 16'sd0, 8'd0, 16'hFFFF, fracs[i]);
         send_flat(10, -16'sd1, 16'd40);
         send_word(16'sd256, 16'd40, 1'b0);
         // equal to the threshold counts as below
         send_word(16'sd0, 16'd40, 1'b0);
         send_word(16'sd0, 16'd40, 1'b1);
      end
   endtask

   task automatic test_clipped_window();
      set_config(8'd4, 16'sd0, 8'd0, 16'hFFFF, 8'd255);
      send_flat(13, -16'sd1, 16'd40);
      send_word(16'sd300, 16'd40, 1'b0);
      send_word(-16'sd5, 16'd40, 1'b0);
      send_word(-16'sd5, 16'd40, 1'b1);
   endtask

   task automatic test_midread_change();
      set_config(8'd8, 16'sd0, 8'd0, 16'hFFFF, 8'd255);
      send_flat(10, -16'sd1, 16'd40);
      send_word(16'sd256, 16'd40, 1'b0);
      send_flat(3, -16'sd1, 16'd40);
      // shrink the window below its current fill; the next word closes it
      wait_idle();
      write_reg(CSR_WIN_LEN, 16'd2);
      send_word(-16'sd1, 16'd40, 1'b0);
      send_word(-16'sd1, 16'd40, 1'b1);
   endtask

   task automatic test_threshold_extremes();
      set_config(8'd1, 16'sh8000, 8'd0, 16'hFFFF, 8'd255);
      send_flat(10, 16'sh8000, 16'd40);
      send_word(16'sh8001, 16'd40, 1'b0);
      send_word(16'sh8000, 16'd40, 1'b0);
      send_word(16'sd0, 16'd40, 1'b1);
   endtask

   task automatic test_zero_window();
      set_config(8'd0, 16'sh7FFF, 8'd255, 16'd1, 8'd0);
      send_flat(11, 16'sh7FFF, 16'hFFFF);
      send_word(16'sh8000, 16'hFFFF, 1'b1);
   endtask

   task automatic test_wide_window();
      set_config(8'd255, 16'sd0, 8'd254, 16'hFFFF, 8'd255);
      send_flat(10, -16'sd1, 16'd530);
      send_flat(255, 16'sd256, 16'd530);
      send_word(-16'sd1, 16'd530, 1'b1);
   endtask

   task automatic test_random_reads(input int unsigned quota);
      int unsigned        start_words;
      logic [7:0]         ws;
      logic [7:0]         mn;
      logic [7:0]         frac;
      logic signed [15:0] thr;
      logic [15:0]        cap;
      start_words = words_scanned + words_skipped;
      while ((words_scanned + words_skipped) - start_words < quota) begin
         case ($urandom_range(9, 0))
            0: ws = 8'd0;
            1: ws = 8'($urandom_range(24, 9));
            default: ws = 8'($urandom_range(8, 1));
         endcase
         case ($urandom_range(7, 0))
            0: thr = 16'sh8000;
            1: thr = 16'sh7FFF;
            default: thr = 16'(int'($urandom_range(1024, 0)) - 512);
         endcase
         mn = ($urandom_range(7, 0) == 0) ? 8'd255 : 8'($urandom_range(3, 0));
         case ($urandom_range(7, 0))
            0: cap = 16'd1;
            1: cap = 16'($urandom_range(40, 2));
            2: cap = 16'($urandom_range(65535, 41));
            default: cap = 16'hFFFF;
         endcase
         case ($urandom_range(5, 0))
            0: frac = 8'd0;
            1: frac = 8'd255;
            default: frac = 8'($urandom_range(254, 1));
         endcase
         src_idle_en = ($urandom_range(3, 0) != 0);
         snk_idle_en = ($urandom_range(3, 0) != 0);
         set_config(ws, thr, mn, cap, frac);
         repeat ($urandom_range(8, 4)) send_random_read();
      end
      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
   endtask

   task automatic test_backpressure();
      set_config(8'd2, 16'sd0, 8'd1, 16'hFFFF, 8'd200);
      src_idle_en = 1'b0;
      hold_cycles = HOLD_STRETCH;
      repeat (40) send_word(16'($urandom_range(65535, 0)), 16'd1, 1'b1);
      repeat (3) send_random_read();
      src_idle_en = 1'b1;
   endtask

   // Result sink: random stalls per word, plus one long hold on request.
   initial begin
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles != 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = snk_idle_en ? $urandom_range(IDLE_MAX, 0) : 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : check_results
      trim_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         trims_seen++;
         if (trim_expect_q.size() == 0) begin
            report_mismatch("trim result with none pending", 32'(rsp_tdata), 0);
         end else begin
            want = trim_expect_q.pop_front();
            if (rsp_tdata !== want.trim_point)
               report_mismatch("trim_point", 32'(rsp_tdata), 32'(want.trim_point));
            if (rsp_tuser !== want.from_window)
               report_mismatch("from_window", 32'(rsp_tuser), 32'(want.from_window));
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Timeout with %0d trim results outstanding", trim_expect_q.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_window_decision();
      test_clipped_window();
      test_midread_change();
      test_threshold_extremes();
      test_zero_window();
      test_wide_window();
      test_backpressure();
      test_random_reads(RANDOM_WORDS);
      wait_idle();
      $display("Covered %0d reads: %0d words scanned, %0d dropped after a decision, %0d settings",
               reads_sent, words_scanned, words_skipped, config_phases);
      $display("Checked %0d trim results, %0d mismatches", trims_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
